@@ rtl/core/asel_pkg.sv @@
// ============================================================================
// asel_pkg: shared types for the activity selection block
// Transaction payloads, queue entry, activity store word, status codes and
// back-end state encoding.
// ============================================================================
`default_nettype none

package asel_pkg;

   // Fixed field widths of the transaction payloads
   localparam int TIME_BITS = 16;
   localparam int POS_W     = 6;
   localparam int ARR_W     = 5;

   // Result status codes
   typedef enum logic [1:0] {
      STAT_SELECTED = 2'd0,
      STAT_INVALID  = 2'd1,
      STAT_OVERFLOW = 2'd2
   } status_type;

   // Input transaction
   typedef struct packed {
      logic [TIME_BITS-1:0] start_time;
      logic [TIME_BITS-1:0] finish_time;
      logic                 last_item;
   } req_type;

   // Result transaction
   typedef struct packed {
      logic [POS_W-1:0]     sorted_position;
      logic [ARR_W-1:0]     arrival_index;
      logic [TIME_BITS-1:0] chosen_start;
      logic [TIME_BITS-1:0] chosen_finish;
      status_type           status;
      logic                 last_result;
   } rsp_type;

   // Classified activity travelling from front end to back end
   typedef struct packed {
      logic [TIME_BITS-1:0] start_time;
      logic [TIME_BITS-1:0] finish_time;
      logic                 last_item;
      logic                 bad;   // start after finish
      logic                 drop;  // store already full
   } entry_type;

   // One word of the activity store
   typedef struct packed {
      logic [TIME_BITS-1:0] start_time;
      logic [TIME_BITS-1:0] finish_time;
      logic [ARR_W-1:0]     arrival;
   } store_type;

   // Back-end sequencer states
   typedef enum logic [2:0] {
      BK_IDLE,
      BK_ERR,
      BK_SORT_GET,
      BK_SORT_CMP,
      BK_SORT_PUT,
      BK_SEL_RD,
      BK_SEL_CHK,
      BK_SEL_FIN
   } back_state_type;

endpackage

`default_nettype wire

@@ rtl/core/asel_front.sv @@
// ============================================================================
// asel_front: input classification
// Flags activities whose start lies after their finish and activities that
// arrive while the store is full, and hands them to the queue.
// ============================================================================
`default_nettype none

module asel_front #(
   parameter int MAX_ACTIVITIES = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire asel_pkg::req_type  req_data,
   output logic                    push_valid,
   input  wire logic               push_ready,
   output asel_pkg::entry_type     push_data
);

   localparam int CNT_W = $clog2(MAX_ACTIVITIES + 1);

   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_in;
   logic             full;
   logic             accept;

   // Classify the incoming transaction
   assign full      = (cnt_ff == CNT_W'(MAX_ACTIVITIES));
   assign accept    = req_valid && push_ready;
   assign req_ready = push_ready;
   assign push_valid = req_valid;

   always_comb begin
      push_data.start_time  = req_data.start_time;
      push_data.finish_time = req_data.finish_time;
      push_data.last_item   = req_data.last_item;
      push_data.bad         = (req_data.start_time > req_data.finish_time);
      push_data.drop        = full;
   end

   // Count stored activities; restart on the final one
   always_comb begin
      cnt_in = cnt_ff;
      if (accept) begin
         if (req_data.last_item) begin
            cnt_in = '0;
         end else if (!full) begin
            cnt_in = cnt_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_ACTIVITIES))
      else $error("front activity count beyond store depth");

endmodule

`default_nettype wire

@@ rtl/core/asel_queue.sv @@
// ============================================================================
// asel_queue: two-entry queue between front and back end
// Lets the front keep taking activities while the back end is busy.
// ============================================================================
`default_nettype none

module asel_queue (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   output logic                       push_ready,
   input  wire asel_pkg::entry_type   push_data,
   output logic                       pop_valid,
   input  wire logic                  pop_ready,
   output asel_pkg::entry_type        pop_data
);

   asel_pkg::entry_type slot_ff [2];
   logic       wp_ff;
   logic       wp_in;
   logic       rp_ff;
   logic       rp_in;
   logic [1:0] cnt_ff;
   logic [1:0] cnt_in;
   logic       do_push;
   logic       do_pop;

   assign push_ready = (cnt_ff != 2'd2);
   assign pop_valid  = (cnt_ff != 2'd0);
   assign pop_data   = slot_ff[rp_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // Advance pointers and occupancy
   always_comb begin
      wp_in  = do_push ? ~wp_ff : wp_ff;
      rp_in  = do_pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff;
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   // Store the pushed entry
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wp_ff] <= push_data;
      end
   end

   a_occupancy: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3)
      else $error("queue occupancy out of range");

endmodule

`default_nettype wire

@@ rtl/core/asel_back.sv @@
// ============================================================================
// asel_back: activity store, exchange sort and greedy selection
// Writes activities into the store, orders them by finish time on the final
// one, then scans the ordered set and registers the selected activities.
// ============================================================================
`default_nettype none

module asel_back #(
   parameter int MAX_ACTIVITIES = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  pop_valid,
   output logic                       pop_ready,
   input  wire asel_pkg::entry_type   pop_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output asel_pkg::rsp_type          rsp_data
);

   localparam int IDX_W = (MAX_ACTIVITIES > 1) ? $clog2(MAX_ACTIVITIES) : 1;
   localparam int CNT_W = $clog2(MAX_ACTIVITIES + 1);
   localparam int EXT_W = 8;

   // Control state
   asel_pkg::back_state_type state_ff, state_in;
   logic [CNT_W-1:0] wp_ff, wp_in;
   logic             inv_ff, inv_in;
   logic             ovf_ff, ovf_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Working registers
   logic [CNT_W-1:0] n_ff, n_in;
   logic [IDX_W-1:0] a_ff, a_in;
   logic [IDX_W-1:0] b_ff, b_in;
   logic [IDX_W-1:0] j_ff, j_in;
   asel_pkg::store_type cur_ff, cur_in;
   logic [asel_pkg::TIME_BITS-1:0] fin_ff, fin_in;
   asel_pkg::rsp_type pend_ff, pend_in;
   asel_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // Activity store
   asel_pkg::store_type mem [MAX_ACTIVITIES];
   asel_pkg::store_type rd_ff;
   logic                mem_we;
   logic [IDX_W-1:0]    mem_wa;
   asel_pkg::store_type mem_wd;
   logic                mem_re;
   logic [IDX_W-1:0]    mem_ra;

   // Helpers
   logic [CNT_W-1:0] n_m1_full;
   logic [IDX_W-1:0] last_idx;
   logic [EXT_W-1:0] wp_ext;
   logic [EXT_W-1:0] pos_ext;
   logic             out_free;
   logic             sel;
   asel_pkg::rsp_type hit;

   assign n_m1_full = n_ff - CNT_W'(1);
   assign last_idx  = n_m1_full[IDX_W-1:0];
   assign wp_ext    = {{(EXT_W-CNT_W){1'b0}}, wp_ff};
   assign pos_ext   = {{(EXT_W-IDX_W){1'b0}}, j_ff} + EXT_W'(1);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign sel       = (j_ff == '0) || (rd_ff.start_time >= fin_ff);

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign pop_ready = (state_ff == asel_pkg::BK_IDLE);

   // Result built from the entry under test
   always_comb begin
      hit.sorted_position = pos_ext[asel_pkg::POS_W-1:0];
      hit.arrival_index   = rd_ff.arrival;
      hit.chosen_start    = rd_ff.start_time;
      hit.chosen_finish   = rd_ff.finish_time;
      hit.status          = asel_pkg::STAT_SELECTED;
      hit.last_result     = 1'b0;
   end

   // Sequence load, sort and selection
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      inv_in       = inv_ff;
      ovf_in       = ovf_ff;
      n_in         = n_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      j_in         = j_ff;
      cur_in       = cur_ff;
      fin_in       = fin_ff;
      pend_in      = pend_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_wa       = wp_ff[IDX_W-1:0];
      mem_wd       = cur_ff;
      mem_re       = 1'b0;
      mem_ra       = a_ff;

      case (state_ff)
         asel_pkg::BK_IDLE: begin
            if (pop_valid) begin
               // Store a kept activity and gather error flags
               if (!pop_data.drop) begin
                  mem_we             = 1'b1;
                  mem_wa             = wp_ff[IDX_W-1:0];
                  mem_wd.start_time  = pop_data.start_time;
                  mem_wd.finish_time = pop_data.finish_time;
                  mem_wd.arrival     = wp_ext[asel_pkg::ARR_W-1:0];
                  wp_in              = wp_ff + CNT_W'(1);
               end
               inv_in = inv_ff || pop_data.bad;
               ovf_in = ovf_ff || pop_data.drop;
               if (pop_data.last_item) begin
                  wp_in = '0;
                  n_in  = wp_ff + CNT_W'(1);
                  if (inv_in || ovf_in) begin
                     state_in = asel_pkg::BK_ERR;
                  end else if (wp_ff == '0) begin
                     j_in     = '0;
                     state_in = asel_pkg::BK_SEL_RD;
                  end else begin
                     a_in     = '0;
                     mem_re   = 1'b1;
                     mem_ra   = '0;
                     state_in = asel_pkg::BK_SORT_GET;
                  end
               end
            end
         end

         asel_pkg::BK_ERR: begin
            if (out_free) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.sorted_position = '0;
               rsp_data_in.arrival_index   = '0;
               rsp_data_in.chosen_start    = '0;
               rsp_data_in.chosen_finish   = '0;
               rsp_data_in.status          = inv_ff ? asel_pkg::STAT_INVALID
                                                    : asel_pkg::STAT_OVERFLOW;
               rsp_data_in.last_result     = 1'b1;
               inv_in                      = 1'b0;
               ovf_in                      = 1'b0;
               state_in                    = asel_pkg::BK_IDLE;
            end
         end

         asel_pkg::BK_SORT_GET: begin
            // Hold entry a, start the inner pass at a+1
            cur_in   = rd_ff;
            b_in     = a_ff + IDX_W'(1);
            mem_re   = 1'b1;
            mem_ra   = a_ff + IDX_W'(1);
            state_in = asel_pkg::BK_SORT_CMP;
         end

         asel_pkg::BK_SORT_CMP: begin
            // Swap when the held finish is strictly greater
            if (cur_ff.finish_time > rd_ff.finish_time) begin
               mem_we = 1'b1;
               mem_wa = b_ff;
               mem_wd = cur_ff;
               cur_in = rd_ff;
            end
            if (b_ff == last_idx) begin
               state_in = asel_pkg::BK_SORT_PUT;
            end else begin
               b_in   = b_ff + IDX_W'(1);
               mem_re = 1'b1;
               mem_ra = b_ff + IDX_W'(1);
            end
         end

         asel_pkg::BK_SORT_PUT: begin
            // Write back entry a, then next outer step or selection
            mem_we = 1'b1;
            mem_wa = a_ff;
            mem_wd = cur_ff;
            if (a_ff + IDX_W'(1) == last_idx) begin
               j_in     = '0;
               state_in = asel_pkg::BK_SEL_RD;
            end else begin
               a_in     = a_ff + IDX_W'(1);
               mem_re   = 1'b1;
               mem_ra   = a_ff + IDX_W'(1);
               state_in = asel_pkg::BK_SORT_GET;
            end
         end

         asel_pkg::BK_SEL_RD: begin
            mem_re   = 1'b1;
            mem_ra   = j_ff;
            state_in = asel_pkg::BK_SEL_CHK;
         end

         asel_pkg::BK_SEL_CHK: begin
            // Hold while an earlier pick cannot be released
            if (!(sel && (j_ff != '0) && !out_free)) begin
               if (sel) begin
                  if (j_ff != '0) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = pend_ff;
                  end
                  pend_in = hit;
                  fin_in  = rd_ff.finish_time;
               end
               if (j_ff == last_idx) begin
                  state_in = asel_pkg::BK_SEL_FIN;
               end else begin
                  j_in     = j_ff + IDX_W'(1);
                  state_in = asel_pkg::BK_SEL_RD;
               end
            end
         end

         asel_pkg::BK_SEL_FIN: begin
            if (out_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in             = pend_ff;
               rsp_data_in.last_result = 1'b1;
               state_in                = asel_pkg::BK_IDLE;
            end
         end

         default: begin
            state_in = asel_pkg::BK_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= asel_pkg::BK_IDLE;
         wp_ff        <= '0;
         inv_ff       <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         inv_ff       <= inv_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Working registers
   always_ff @(posedge clock) begin
      n_ff        <= n_in;
      a_ff        <= a_in;
      b_ff        <= b_in;
      j_ff        <= j_in;
      cur_ff      <= cur_in;
      fin_ff      <= fin_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Activity store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_ff <= mem[mem_ra];
      end
   end

   a_write_phase: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == asel_pkg::BK_IDLE || state_ff == asel_pkg::BK_SORT_CMP ||
                  state_ff == asel_pkg::BK_SORT_PUT))
      else $error("store written outside load or sort");

   a_inner_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == asel_pkg::BK_SORT_CMP) |-> (b_ff > a_ff))
      else $error("inner sort index not above outer index");

   a_run_size: assert property (@(posedge clock) disable iff (reset)
      (state_ff == asel_pkg::BK_SORT_GET || state_ff == asel_pkg::BK_SORT_CMP ||
       state_ff == asel_pkg::BK_SEL_RD || state_ff == asel_pkg::BK_SEL_CHK) |->
      (n_ff != '0))
      else $error("run started with an empty store");

   a_error_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_data_ff.status != asel_pkg::STAT_SELECTED) |->
      rsp_data_ff.last_result)
      else $error("error result not marked final");

endmodule

`default_nettype wire

@@ rtl/core/activity_selection_sorted.sv @@
// ============================================================================
// activity_selection_sorted: greedy activity selection over a stored set
// Loads activities, orders them by finish time with a pairwise exchange
// sort, and returns the activities chosen by the greedy rule.
// ============================================================================
//
//   channel  direction  payload         handshake
//   req_     in         asel_pkg::req_type   req_valid / req_ready
//   rsp_     out        asel_pkg::rsp_type   rsp_valid / rsp_ready
//
// Loading takes one activity per cycle through a two-entry queue while the
// back end is idle. The final activity of a set starts a run in the back end:
// an exchange sort by finish time, then the selection scan, all bound by the
// single read and write port of the activity store.
// While a run is active the queue fills and then holds req_ready low.
// A held result stalls the selection scan; synchronous reset empties all.
`default_nettype none

module activity_selection_sorted #(
   parameter int MAX_ACTIVITIES = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire asel_pkg::req_type  req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output asel_pkg::rsp_type       rsp_data
);

   logic                push_valid;
   logic                push_ready;
   asel_pkg::entry_type push_data;
   logic                pop_valid;
   logic                pop_ready;
   asel_pkg::entry_type pop_data;

   asel_front #(
      .MAX_ACTIVITIES(MAX_ACTIVITIES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data)
   );

   asel_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_ready(push_ready),
      .push_data (push_data),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data)
   );

   asel_back #(
      .MAX_ACTIVITIES(MAX_ACTIVITIES)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .pop_valid(pop_valid),
      .pop_ready(pop_ready),
      .pop_data (pop_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule

`default_nettype wire
